// ===== src/ole_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ole_pkg;

    localparam int VALUE_W = 32;

    typedef enum logic [1:0] {
        REQ_FRONT  = 2'd0,
        REQ_BACK   = 2'd1,
        REQ_DELETE = 2'd2,
        REQ_LIST   = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_MISSING = 2'd3
    } t_status;

    // Where the value of an outgoing result comes from.
    typedef enum logic [1:0] {
        SRC_REQ  = 2'd0,
        SRC_CELL = 2'd1,
        SRC_ZERO = 2'd2
    } t_src;

    typedef struct packed {
        logic    load_req;
        logic    ins_front;
        logic    ins_back;
        logic    del_shift;
        logic    cap_match;
        logic    idx_clr;
        logic    idx_inc;
        logic    out_load;
        t_status out_status;
        t_src    out_src;
    } t_cmd;

    typedef struct packed {
        t_req req;
        logic full;
        logic empty;
        logic found;
        logic list_last;
        logic slot_free;
    } t_dp_status;

endpackage

`default_nettype wire

// ===== src/ole_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ole_dp #(
    parameter int CAPACITY = 16
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire  [ole_pkg::VALUE_W-1:0] i_value,
    input  wire  [1:0]                  i_req,
    input  wire  ole_pkg::t_cmd         i_cmd,
    output ole_pkg::t_dp_status         o_status,
    input  wire                         i_out_ready,
    output logic                        o_out_valid,
    output logic [ole_pkg::VALUE_W-1:0] o_out_value,
    output logic [1:0]                  o_out_status,
    output logic                        o_out_last
);
    import ole_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    // Cell chain, entry 0 is the front. No reset: only cells below the count are read.
    logic [VALUE_W-1:0] r_cell [CAPACITY];
    logic [VALUE_W-1:0] n_cell [CAPACITY];
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic [IDX_W-1:0]   r_idx;
    logic [CAPACITY-1:0] r_match;
    logic [CAPACITY-1:0] match;
    logic [CAPACITY-1:0] first_hit;
    logic [CAPACITY-1:0] at_or_after;
    logic [VALUE_W-1:0] r_val;
    t_req               r_req;
    logic [VALUE_W-1:0] r_out_value;
    logic [1:0]         r_out_status;
    logic               r_out_last;
    logic               r_out_valid;
    logic [VALUE_W-1:0] out_value;
    logic               list_last;

    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            match[i] = (r_cell[i] == r_val) && (CNT_W'(i) < r_count);
        end
    end

    // Isolate the match nearest the front, then mark it and every cell behind it.
    assign first_hit   = r_match & (~r_match + CAPACITY'(1));
    assign at_or_after = ~(first_hit - CAPACITY'(1));

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [VALUE_W-1:0] from_front;
        logic [VALUE_W-1:0] from_back;
        if (g == 0) begin : g_head
            assign from_front = r_val;
        end else begin : g_body
            assign from_front = r_cell[g-1];
        end
        if (g == CAPACITY - 1) begin : g_tail
            assign from_back = r_cell[g];
        end else begin : g_inner
            assign from_back = r_cell[g+1];
        end
        always_comb begin
            n_cell[g] = r_cell[g];
            if (i_cmd.ins_front) begin
                n_cell[g] = from_front;
            end else if (i_cmd.ins_back && (r_count == CNT_W'(g))) begin
                n_cell[g] = r_val;
            end else if (i_cmd.del_shift && at_or_after[g]) begin
                n_cell[g] = from_back;
            end
        end
        always_ff @(posedge i_clk) begin
            r_cell[g] <= n_cell[g];
        end
    end

    always_comb begin
        n_count = r_count;
        if (i_cmd.ins_front || i_cmd.ins_back) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_cmd.del_shift) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    assign list_last = (CNT_W'(r_idx) + CNT_W'(1)) == r_count;

    always_comb begin
        case (i_cmd.out_src)
            SRC_REQ:  out_value = r_val;
            SRC_CELL: out_value = r_cell[r_idx];
            default:  out_value = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_val <= i_value;
            r_req <= t_req'(i_req);
        end
        if (i_cmd.cap_match) begin
            r_match <= match;
        end
        if (i_cmd.idx_clr) begin
            r_idx <= '0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + IDX_W'(1);
        end
        if (i_cmd.out_load) begin
            r_out_value  <= out_value;
            r_out_status <= i_cmd.out_status;
            r_out_last   <= (i_cmd.out_src == SRC_CELL) ? list_last : 1'b1;
        end
    end

    assign o_status.req       = r_req;
    assign o_status.full      = (r_count == CNT_W'(CAPACITY));
    assign o_status.empty     = (r_count == '0);
    assign o_status.found     = |r_match;
    assign o_status.list_last = list_last;
    assign o_status.slot_free = !r_out_valid || i_out_ready;

    assign o_out_valid  = r_out_valid;
    assign o_out_value  = r_out_value;
    assign o_out_status = r_out_status;
    assign o_out_last   = r_out_last;

endmodule

`default_nettype wire

// ===== src/ole_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ole_ctrl (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_in_valid,
    output logic                     o_in_ready,
    input  wire ole_pkg::t_dp_status i_status,
    output ole_pkg::t_cmd            o_cmd
);
    import ole_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_DEL  = 4'b0100,
        S_LIST = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_req = 1'b1;
                    n_state        = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_status.slot_free) begin
                    case (i_status.req) inside
                        REQ_FRONT, REQ_BACK: begin
                            o_cmd.out_load = 1'b1;
                            o_cmd.out_src  = SRC_REQ;
                            if (i_status.full) begin
                                o_cmd.out_status = ST_FULL;
                            end else begin
                                o_cmd.out_status = ST_OK;
                                o_cmd.ins_front  = (i_status.req == REQ_FRONT);
                                o_cmd.ins_back   = (i_status.req == REQ_BACK);
                            end
                            n_state = S_IDLE;
                        end
                        REQ_DELETE: begin
                            if (i_status.empty) begin
                                o_cmd.out_load   = 1'b1;
                                o_cmd.out_src    = SRC_REQ;
                                o_cmd.out_status = ST_EMPTY;
                                n_state          = S_IDLE;
                            end else begin
                                o_cmd.cap_match = 1'b1;
                                n_state         = S_DEL;
                            end
                        end
                        default: begin
                            if (i_status.empty) begin
                                o_cmd.out_load   = 1'b1;
                                o_cmd.out_src    = SRC_ZERO;
                                o_cmd.out_status = ST_EMPTY;
                                n_state          = S_IDLE;
                            end else begin
                                o_cmd.idx_clr = 1'b1;
                                n_state       = S_LIST;
                            end
                        end
                    endcase
                end
            end
            S_DEL: begin
                if (i_status.slot_free) begin
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_src    = SRC_REQ;
                    o_cmd.out_status = i_status.found ? ST_OK : ST_MISSING;
                    o_cmd.del_shift  = i_status.found;
                    n_state          = S_IDLE;
                end
            end
            S_LIST: begin
                if (i_status.slot_free) begin
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_src    = SRC_CELL;
                    o_cmd.out_status = ST_OK;
                    if (i_status.list_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ===== src/ordered_list_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Ordered list engine: holds up to CAPACITY signed 32-bit values in a chain of
// registers with the front at entry 0, and serves one request at a time from the
// slave stream. The request kind arrives in tuser (insert at front, append at back,
// delete first match, list all) and the value in tdata. Insert and delete each answer
// with one result item carrying a status (ok, full, empty or not found) and the
// request value, always with tlast set. A listing answers with one item per entry
// from front to back, tlast on the final one, or a single empty status with value
// zero. An insert or append loads its result in the execute state; a delete first
// registers the compare of all cells, then closes the gap as its result is loaded.
// A listing reads the chain through one read port, at one entry per cycle while the
// output is not stalled. The input is ready again as soon as the last result of a
// request is loaded into the output register, so the next request can be taken
// while that result still waits downstream. A stalled output simply holds the
// controller in place.
module ordered_list_engine #(
    parameter int CAPACITY = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire  [31:0] i_s_axis_tdata,   // [31:0] item_value
    input  wire  [1:0]  i_s_axis_tuser,   // [1:0] req_type
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // [31:0] entry_value
    output logic [1:0]  o_m_axis_tuser,   // [1:0] status
    output logic        o_m_axis_tlast
);
    import ole_pkg::*;

    t_cmd       cmd;
    t_dp_status dp_status;

    ole_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_status   (dp_status),
        .o_cmd      (cmd)
    );

    ole_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_value      (i_s_axis_tdata),
        .i_req        (i_s_axis_tuser),
        .i_cmd        (cmd),
        .o_status     (dp_status),
        .i_out_ready  (i_m_axis_tready),
        .o_out_valid  (o_m_axis_tvalid),
        .o_out_value  (o_m_axis_tdata),
        .o_out_status (o_m_axis_tuser),
        .o_out_last   (o_m_axis_tlast)
    );

    // The count can never read both full and empty.
    a_full_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(dp_status.full && dp_status.empty))
        else $error("list reports full and empty at once");

    // The engine is never ready in the cycle after it takes a request.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("input ready right after an accepted item");

    // Every status other than ok ends its request.
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tuser != ST_OK)) |-> o_m_axis_tlast)
        else $error("error status without last mark");

    // Only one write operation may act on the cell chain in a cycle.
    a_one_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({cmd.ins_front, cmd.ins_back, cmd.del_shift}) <= 1)
        else $error("conflicting cell chain updates");

endmodule

`default_nettype wire
